// ----- rtl/flpc_pkg.sv -----
// ----------------------------------------------------------------------------
// flpc_pkg
// Shared types and constants for the linear-phase FIR crossover.
// ----------------------------------------------------------------------------
package flpc_pkg;

	localparam int BANDS = 4;
	localparam int TAP_BITS = 24;
	localparam int TAP_FRAC = 22;
	localparam int ACC_BITS = 64;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TAP    = 1'b1;

	localparam logic CFG_SPLITS = 1'b0;
	localparam logic CFG_KERNEL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_MAC,
		ST_DRAIN,
		ST_FINISH,
		ST_OUT
	} be_state_t;

endpackage

// ----- rtl/flpc_ram.sv -----
// ----------------------------------------------------------------------------
// flpc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module flpc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/flpc_front.sv -----
// ----------------------------------------------------------------------------
// flpc_front
// Accepts items, drops out-of-range ones, pushes the rest to a 2-entry queue.
// ----------------------------------------------------------------------------
module flpc_front
	import flpc_pkg::*;
#(
	parameter int CHANNELS = 2,
	parameter int SAMPLE_BITS = 24,
	parameter int CH_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   in_command,
	input  logic [CH_W-1:0]        in_channel,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic [1:0]             in_tap_split,
	input  logic [5:0]             in_tap_index,
	input  logic [TAP_BITS-1:0]    in_tap_value,
	input  logic [2:0]             max_splits,
	input  logic [8:0]             taps,
	output logic                   q_valid,
	input  logic                   q_pop,
	output logic                   q_command,
	output logic [CH_W-1:0]        q_channel,
	output logic [SAMPLE_BITS-1:0] q_sample,
	output logic [1:0]             q_tap_split,
	output logic [5:0]             q_tap_index,
	output logic [TAP_BITS-1:0]    q_tap_value
);
	localparam int EW = 1 + CH_W + SAMPLE_BITS + 2 + 6 + TAP_BITS;

	logic [EW-1:0] ent_q [2];
	logic [1:0]    cnt_q;
	logic          rd_q, wr_q;
	logic          acc, keep, push;

	assign in_stall = (cnt_q == 2'd2);
	assign acc = in_valid && !in_stall;
	always_comb begin
		if (in_command == CMD_TAP) begin
			keep = ({1'b0, in_tap_split} < max_splits) && ({3'b0, in_tap_index} < taps);
		end else begin
			keep = (32'(in_channel) < CHANNELS);
		end
	end
	assign push = acc && keep;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= {in_command, in_channel, in_sample, in_tap_split,
				in_tap_index, in_tap_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign {q_command, q_channel, q_sample, q_tap_split, q_tap_index, q_tap_value} =
		ent_q[rd_q];

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> in_stall) else $error("full queue not stalling");
endmodule

// ----- rtl/flpc_back.sv -----
// ----------------------------------------------------------------------------
// flpc_back
// Executes queued items: tap writes, and per-sample MAC walk over the active splits.
// ----------------------------------------------------------------------------
module flpc_back
	import flpc_pkg::*;
#(
	parameter int MAX_SPLITS = 3,
	parameter int TAPS = 63,
	parameter int CHANNELS = 2,
	parameter int SAMPLE_BITS = 24,
	parameter int CH_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             splits_in_use,
	input  logic [5:0]             kern_len,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  logic                   q_command,
	input  logic [CH_W-1:0]        q_channel,
	input  logic [SAMPLE_BITS-1:0] q_sample,
	input  logic [1:0]             q_tap_split,
	input  logic [5:0]             q_tap_index,
	input  logic [TAP_BITS-1:0]    q_tap_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CH_W-1:0]        out_channel,
	output logic [SAMPLE_BITS-1:0] band_0,
	output logic [SAMPLE_BITS-1:0] band_1,
	output logic [SAMPLE_BITS-1:0] band_2,
	output logic [SAMPLE_BITS-1:0] band_3
);
	localparam int TW  = $clog2(TAPS + 1);
	localparam int PW  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int HD  = CHANNELS * TAPS;
	localparam int HAW = $clog2(HD);
	localparam int TD  = MAX_SPLITS * TAPS;
	localparam int TAW = $clog2(TD);
	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PRW = SAMPLE_BITS + TAP_BITS;
	localparam int LPW = ACC_BITS - TAP_FRAC;
	localparam int SPL_LIM = (MAX_SPLITS < BANDS - 1) ? MAX_SPLITS : BANDS - 1;

	be_state_t st_q, st_d;

	// ring write positions, flip-flops (few channels)
	logic [PW-1:0] wpos_q [CHANNELS];
	// valid bits for history and tap rows (entries read as zero until written)
	logic [HD-1:0] hval_q;
	logic [TD-1:0] tval_q;

	logic [CH_W-1:0]        ch_q;
	logic [CW-1:0]          chi;
	logic [PW-1:0]          wp_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic [TW-1:0]          len_q;
	logic [1:0]             spl_q;
	logic [1:0]             s_q;
	logic [TW-1:0]          t_q;
	logic                   dly_q;   // delayed-sample fetch phase
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [LPW-1:0]  lp_q [BANDS];
	logic signed [SAMPLE_BITS-1:0] dly_smp_q;

	// pipeline: address issue -> RAM read (s1) -> product (s2)
	logic                   v_s1, v_s2;
	logic                   last_s1, last_s2, dly_s1;
	logic                   hv_s1, tv_s1;
	logic signed [PRW-1:0]  prod_s2;
	// split index and row-end flag travel with each product
	logic [1:0]             sidx_s1, sidx_s2;
	logic                   t_fin_s1, t_fin_s2;

	// RAM ports
	logic                   h_we, t_we;
	logic [HAW-1:0]         h_waddr, h_raddr;
	logic [TAW-1:0]         t_waddr, t_raddr;
	logic [SAMPLE_BITS-1:0] h_wdata, h_rdata;
	logic [TAP_BITS-1:0]    t_rdata;

	flpc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HD)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata));
	flpc_ram #(.WIDTH(TAP_BITS), .DEPTH(TD)) u_taps (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(q_tap_value),
		.raddr(t_raddr), .rdata(t_rdata));

	assign chi = CW'(q_channel);

	// history read address: channel row, ring position wp - offset
	logic [TW-1:0] offs;
	logic [PW:0]   rp_sum;
	logic [PW-1:0] rp;
	always_comb begin
		offs = dly_q ? (len_q >> 1) : t_q;
		rp_sum = {1'b0, wp_q} + (PW+1)'(TAPS) - (PW+1)'(offs);
		rp = (rp_sum >= (PW+1)'(TAPS)) ? PW'(rp_sum - (PW+1)'(TAPS)) : PW'(rp_sum);
	end
	assign h_raddr = HAW'(32'(ch_q) * TAPS + 32'(rp));
	assign t_raddr = TAW'(32'(s_q) * TAPS + 32'(t_q));
	assign t_waddr = TAW'(32'(q_tap_split) * TAPS + 32'(q_tap_index));
	assign h_waddr = HAW'(32'(ch_q) * TAPS + 32'(wp_q));
	assign h_wdata = smp_q;
	assign t_we = (st_q == ST_IDLE) && q_valid && (q_command == CMD_TAP);
	assign h_we = (st_q == ST_WRITE);

	logic issue, last_iss;
	assign issue = (st_q == ST_MAC);
	// with no split the delayed fetch is the only read
	assign last_iss = dly_q ? (spl_q == 2'd0)
		: ((t_q == len_q - TW'(1)) && (s_q == spl_q - 2'd1));

	// band forming from rounded low-passes
	logic signed [LPW:0] bd [BANDS];
	logic signed [LPW-1:0] prev;
	always_comb begin
		prev = '0;
		for (int b = 0; b < BANDS; b++) begin
			bd[b] = '0;
		end
		for (int b = 0; b < BANDS - 1; b++) begin
			if (2'(b) < spl_q) begin
				bd[b] = (LPW+1)'(lp_q[b]) - ((b == 0) ? '0 : (LPW+1)'(prev));
				prev = lp_q[b];
			end
		end
		bd[spl_q] = (LPW+1)'(dly_smp_q) - (LPW+1)'(prev);
	end

	function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [LPW:0] v);
		logic signed [LPW:0] hi, lo;
		hi = (LPW+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[SAMPLE_BITS-1:0];
		if (v < lo) return lo[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1:0];
	endfunction

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_command == CMD_SAMPLE) st_d = ST_WRITE;
				end
			end
			ST_WRITE: st_d = ST_MAC;
			ST_MAC:   if (last_iss) st_d = ST_DRAIN;
			ST_DRAIN: if (last_s2) st_d = ST_FINISH;
			ST_FINISH: st_d = ST_OUT;
			ST_OUT:   if (!out_stall) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	assign out_valid = (st_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			hval_q <= '0;
			tval_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) wpos_q[c] <= '0;
		end else begin
			st_q <= st_d;
			v_s1 <= issue;
			v_s2 <= v_s1 && !dly_s1;
			if (t_we) tval_q[t_waddr] <= 1'b1;
			if (h_we) begin
				hval_q[h_waddr] <= 1'b1;
				wpos_q[CW'(ch_q)] <= (wp_q == PW'(TAPS - 1)) ? '0 : wp_q + PW'(1);
			end
		end
	end

	logic [TW-1:0] len_c;
	logic [1:0]    spl_c;
	always_comb begin
		len_c = (32'(kern_len) > TAPS) ? TW'(TAPS) : TW'(kern_len);
		if (len_c == '0) len_c = TW'(1);
		spl_c = (32'(splits_in_use) > SPL_LIM) ? 2'(SPL_LIM) : splits_in_use;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid && q_command == CMD_SAMPLE) begin
			ch_q <= q_channel;
			wp_q <= wpos_q[chi];
			smp_q <= q_sample;
			len_q <= len_c;
			spl_q <= spl_c;
			s_q <= '0;
			t_q <= '0;
			dly_q <= 1'b1;
			acc_q <= '0;
		end
		if (issue && !dly_q) begin
			if (t_q == len_q - TW'(1)) begin
				t_q <= '0;
				s_q <= s_q + 2'd1;
			end else begin
				t_q <= t_q + TW'(1);
			end
		end
		if (issue) begin
			dly_q <= 1'b0;
		end
		last_s1 <= issue && (dly_q ? (spl_q == 2'd0) : last_iss);
		last_s2 <= last_s1 && v_s1;
		dly_s1 <= dly_q;
		hv_s1 <= hval_q[h_raddr];
		tv_s1 <= tval_q[t_raddr];
		if (v_s1 && dly_s1) dly_smp_q <= hv_s1 ? h_rdata : '0;
		prod_s2 <= $signed(hv_s1 ? h_rdata : '0) * $signed(tv_s1 ? t_rdata : '0);
		if (v_s2) begin
			// accumulate and close a split row on its final tap
			if (t_fin_s2) begin
				lp_q[sidx_s2] <= LPW'((acc_q + ACC_BITS'(prod_s2)
					+ (ACC_BITS'(1) <<< (TAP_FRAC - 1))) >>> TAP_FRAC);
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + ACC_BITS'(prod_s2);
			end
		end
		if (st_q == ST_FINISH) begin
			out_channel <= ch_q;
			band_0 <= sat(bd[0]);
			band_1 <= sat(bd[1]);
			band_2 <= sat(bd[2]);
			band_3 <= sat(bd[3]);
		end
	end

	always_ff @(posedge clk) begin
		sidx_s1 <= s_q;
		t_fin_s1 <= !dly_q && (t_q == len_q - TW'(1));
		sidx_s2 <= sidx_s1;
		t_fin_s2 <= t_fin_s1;
	end

	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_pop) else $error("pop during output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_no_we: assert property (@(posedge clk) disable iff (!arst_n)
		!(h_we && t_we)) else $error("both rams written");
endmodule

// ----- rtl/fir_linear_phase_crossover_top.sv -----
// ----------------------------------------------------------------------------
// fir_linear_phase_crossover_top
// Linear-phase FIR multiband crossover, up to four bands.
// ----------------------------------------------------------------------------
// Each sample item yields one result of four bands; tap-write items load one
// low-pass coefficient and give no result. A small front stage takes items
// into a two-entry queue; the back end runs one multiply-accumulate per cycle
// over every active split's tap row. History and tap rows live in RAMs;
// entries never written read as zero. Results wait in an output register
// while the queue keeps filling.
module fir_linear_phase_crossover_top
	import flpc_pkg::*;
#(
	parameter int MAX_SPLITS = 3,
	parameter int TAPS = 63,
	parameter int CHANNELS = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [5:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic                   channel,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [1:0]             tap_split,
	input  logic [5:0]             tap_index,
	input  logic [TAP_BITS-1:0]    tap_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   out_channel,
	output logic [SAMPLE_BITS-1:0] band_0,
	output logic [SAMPLE_BITS-1:0] band_1,
	output logic [SAMPLE_BITS-1:0] band_2,
	output logic [SAMPLE_BITS-1:0] band_3
);
	logic [1:0] splits_q;
	logic [5:0] kernel_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			splits_q <= 2'd0;
			kernel_q <= 6'd63;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SPLITS) splits_q <= cfg_data[1:0];
			else kernel_q <= cfg_data;
		end
	end

	logic                   q_valid, q_pop, q_command, q_channel;
	logic [SAMPLE_BITS-1:0] q_sample;
	logic [1:0]             q_tap_split;
	logic [5:0]             q_tap_index;
	logic [TAP_BITS-1:0]    q_tap_value;

	flpc_front #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS), .CH_W(1)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_command(command), .in_channel(channel), .in_sample(sample),
		.in_tap_split(tap_split), .in_tap_index(tap_index), .in_tap_value(tap_value),
		.max_splits(3'(MAX_SPLITS)), .taps(9'(TAPS)),
		.q_valid(q_valid), .q_pop(q_pop), .q_command(q_command),
		.q_channel(q_channel), .q_sample(q_sample), .q_tap_split(q_tap_split),
		.q_tap_index(q_tap_index), .q_tap_value(q_tap_value));

	flpc_back #(.MAX_SPLITS(MAX_SPLITS), .TAPS(TAPS), .CHANNELS(CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS), .CH_W(1)) u_back (
		.clk(clk), .arst_n(arst_n), .splits_in_use(splits_q), .kern_len(kernel_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_command(q_command),
		.q_channel(q_channel), .q_sample(q_sample), .q_tap_split(q_tap_split),
		.q_tap_index(q_tap_index), .q_tap_value(q_tap_value),
		.out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
		.band_0(band_0), .band_1(band_1), .band_2(band_2), .band_3(band_3));
endmodule

// ----- dv/tb_fir_linear_phase_crossover_top.sv -----
// ----------------------------------------------------------------------------
// tb_fir_linear_phase_crossover_top
// Self-checking bench for the FIR crossover: a bit-exact predictor of the
// band math runs beside the block, and every result item is compared
// field by field in order.
// ----------------------------------------------------------------------------
module tb_fir_linear_phase_crossover_top;
	import flpc_pkg::*;

	localparam int NSPLIT = 3;
	localparam int NTAPS = 63;
	localparam int NCH = 2;
	localparam int SBITS = 24;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic              ch;
		logic [SBITS-1:0]  b0;
		logic [SBITS-1:0]  b1;
		logic [SBITS-1:0]  b2;
		logic [SBITS-1:0]  b3;
	} bands_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_SPLITS;
	logic [5:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_SAMPLE;
	logic channel = 1'b0;
	logic [SBITS-1:0] sample = '0;
	logic [1:0] tap_split = '0;
	logic [5:0] tap_index = '0;
	logic [TAP_BITS-1:0] tap_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic out_channel;
	logic [SBITS-1:0] band_0, band_1, band_2, band_3;

	// predictor state
	logic signed [SBITS-1:0] hist [NCH][NTAPS];
	int unsigned wpos [NCH];
	logic signed [TAP_BITS-1:0] taps [NSPLIT][NTAPS];
	int unsigned splits_reg;
	int unsigned kernel_reg;

	bands_t expected_bands[$];
	int errors = 0;
	int cycles = 0;
	bit idle_on = 1'b1;

	always #5 clk = ~clk;

	fir_linear_phase_crossover_top uut (.*);

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h", what, got, want);
	endtask

	function automatic logic [SBITS-1:0] sat24(input longint v);
		if (v > 64'sd8388607) return 24'h7fffff;
		if (v < -64'sd8388608) return 24'h800000;
		return v[SBITS-1:0];
	endfunction

	// advance the history of one channel and form its bands
	function automatic bands_t split_bands(input logic ch, input logic [SBITS-1:0] x);
		bands_t r;
		longint band [4];
		longint acc, lp, prev, dly;
		int unsigned len, ns, wp;
		len = (kernel_reg > NTAPS) ? NTAPS : kernel_reg;
		if (len == 0) len = 1;
		ns = splits_reg;
		wp = wpos[ch] % NTAPS;
		hist[ch][wp] = x;
		dly = hist[ch][(wp + NTAPS - len / 2) % NTAPS];
		band = '{default: 0};
		prev = 0;
		for (int s = 0; s < ns; s++) begin
			acc = 0;
			for (int t = 0; t < len; t++)
				acc += longint'(hist[ch][(wp + NTAPS - t) % NTAPS]) * longint'(taps[s][t]);
			lp = (acc + (64'sd1 <<< (TAP_FRAC - 1))) >>> TAP_FRAC;
			band[s] = (s == 0) ? lp : lp - prev;
			prev = lp;
		end
		band[ns] = dly - prev;
		wpos[ch] = (wp + 1) % NTAPS;
		r.ch = ch;
		r.b0 = sat24(band[0]);
		r.b1 = sat24(band[1]);
		r.b2 = sat24(band[2]);
		r.b3 = sat24(band[3]);
		return r;
	endfunction

	task automatic idle_burst();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	// one input item; prediction on acceptance
	task automatic send_item(input logic cmd, input logic ch, input logic [23:0] smp,
			input logic [1:0] ts, input logic [5:0] ti, input logic [23:0] tv);
		idle_burst();
		command <= cmd; channel <= ch; sample <= smp;
		tap_split <= ts; tap_index <= ti; tap_value <= tv;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (cmd == CMD_TAP) begin
			if (ts < NSPLIT && ti < NTAPS) taps[ts][ti] = tv;
		end else
			expected_bands.insert(expected_bands.size(), split_bands(ch, smp));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_bands.size() != 0) @(negedge clk);
		repeat (220) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] val);
		drain();
		cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_SPLITS) splits_reg = val[1:0];
		else kernel_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic rand_taps(input int n);
		for (int i = 0; i < n; i++)
			send_item(CMD_TAP, 1'b0, 24'($urandom), 2'($urandom_range(0, 2)),
				6'($urandom_range(0, 62)),
				24'($urandom_range(0, 1) ? $urandom : $urandom >>> 3));
	endtask

	// result checker; stalls in bursts
	always @(posedge clk) begin
		bands_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bands.size() == 0) begin
				report("unexpected result", 32'(out_channel), 32'd0);
			end else begin
				want = expected_bands.pop_front();
				if (out_channel !== want.ch) report("out_channel", out_channel, want.ch);
				if (band_0 !== want.b0) report("band_0", band_0, want.b0);
				if (band_1 !== want.b1) report("band_1", band_1, want.b1);
				if (band_2 !== want.b2) report("band_2", band_2, want.b2);
				if (band_3 !== want.b3) report("band_3", band_3, want.b3);
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 15) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// directed: extremes, both commands, ignored tap addresses, no-split path
	task automatic test_directed();
		send_item(CMD_SAMPLE, 1'b0, 24'h7fffff, 2'd0, 6'd0, 24'h0);
		send_item(CMD_SAMPLE, 1'b1, 24'h800000, 2'd3, 6'd63, 24'hffffff);
		send_item(CMD_TAP, 1'b0, 24'h0, 2'd3, 6'd5, 24'h400000);
		send_item(CMD_TAP, 1'b0, 24'h0, 2'd0, 6'd63, 24'h400000);
		send_item(CMD_TAP, 1'b1, 24'hffffff, 2'd0, 6'd0, 24'h7fffff);
		send_item(CMD_TAP, 1'b0, 24'h0, 2'd1, 6'd62, 24'h800000);
		send_item(CMD_TAP, 1'b0, 24'h0, 2'd2, 6'd1, 24'h400000);
		write_reg(CFG_SPLITS, 6'd3);
		write_reg(CFG_KERNEL, 6'd63);
		for (int i = 0; i < 6; i++)
			send_item(CMD_SAMPLE, i[0], i[1] ? 24'h7fffff : 24'h800000, 2'd0, 6'd0, 24'h0);
		write_reg(CFG_KERNEL, 6'd3);
		for (int i = 0; i < 4; i++)
			send_item(CMD_SAMPLE, i[0], 24'($urandom), 2'd0, 6'd0, 24'h0);
	endtask

	// random: several settings, mostly small kernels
	task automatic test_random();
		int unsigned kern;
		for (int ph = 0; ph < 25; ph++) begin
			if (ph == 22) idle_on = 1'b0;
			kern = (ph % 6 == 5) ? 63 : 3 + 2 * $urandom_range(0, 8);
			if (ph == 3) kern = 0;
			if (ph == 4) kern = 8;
			write_reg(CFG_SPLITS, 6'($urandom_range(0, 3)));
			write_reg(CFG_KERNEL, 6'(kern));
			rand_taps($urandom_range(2, 12));
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(0, 9) == 0) rand_taps(1);
				send_item(CMD_SAMPLE, 1'($urandom_range(0, 1)),
					($urandom_range(0, 7) == 0) ? {$urandom_range(0, 1) ? 24'h7fffff : 24'h800000}
						: 24'($urandom), 2'd0, 6'd0, 24'h0);
			end
		end
	endtask

	initial begin
		for (int c = 0; c < NCH; c++) begin
			wpos[c] = 0;
			for (int t = 0; t < NTAPS; t++) hist[c][t] = '0;
		end
		for (int s = 0; s < NSPLIT; s++)
			for (int t = 0; t < NTAPS; t++) taps[s][t] = '0;
		splits_reg = 0;
		kernel_reg = 63;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
